FILE: hdl/wpu_pkg.sv
// ----------------------------------------------------------------------------
// wpu_pkg
// Shared widths, constants and the small divide-by-three helper used by the
// wolf pack position update pipeline.
// ----------------------------------------------------------------------------
package wpu_pkg;

    localparam int VAL_W  = 32;   // Q16.16 values
    localparam int RND_W  = 16;   // Q0.16 random fractions
    localparam int COEF_W = 18;   // Q2.16 coefficient a
    localparam int TERM_W = 54;   // one leader term in Q.32
    localparam int SUM_W  = 55;   // sum of three terms in Q.32
    localparam int MQ_W   = 39;   // rounded magnitude before the divide by three

    localparam logic [COEF_W-1:0] A_COEFF_RESET = 18'd131072;

    // Rounded magnitudes at or above these saturate the mean.
    localparam logic [MQ_W-1:0] SAT_POS_LIM = 39'd6442450944;
    localparam logic [MQ_W-1:0] SAT_NEG_LIM = 39'd6442450947;

    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [VAL_W-1:0] lo;
        logic signed [VAL_W-1:0] hi;
    } wpu_limits_t;

    // Exact floor(n / 3) for any n below 2^19, by a reciprocal multiply.
    function automatic logic [17:0] div3(input logic [18:0] n);
        logic [37:0] prod;
        prod = {19'd0, n} * 38'd349526;
        return prod[37:20];
    endfunction

endpackage

FILE: hdl/wpu_term.sv
// ----------------------------------------------------------------------------
// wpu_term
// Four-stage pipeline for one leader term X = L - A*D in Q.32.
// ----------------------------------------------------------------------------
module wpu_term
    import wpu_pkg::*;
(
    input  logic                     clk,
    input  logic [COEF_W-1:0]        a_coeff,
    input  logic signed [VAL_W-1:0]  lead,
    input  logic signed [VAL_W-1:0]  pos,
    input  logic [RND_W-1:0]         rand_a,
    input  logic [RND_W-1:0]         rand_c,
    output logic signed [TERM_W-1:0] term
);

    // Stage 1: a * (2*r1 - 1) and r2 * L.
    logic signed [17:0]       r1_off;
    logic signed [36:0]       a32_next, a32_reg;
    logic signed [48:0]       p_next, p_reg;
    logic signed [VAL_W-1:0]  lead_s1_reg, pos_s1_reg;

    // Stage 2: rounded A and D.
    logic signed [49:0]       diff;
    logic [49:0]              dmag, dsum;
    logic [36:0]              amag, asum;
    logic signed [18:0]       a16_next, a16_reg;
    logic [33:0]              d16_next, d16_reg;
    logic signed [VAL_W-1:0]  lead_s2_reg;

    // Stage 3: A * D.
    logic signed [53:0]       prod_next, prod_reg;
    logic signed [VAL_W-1:0]  lead_s3_reg;

    // Stage 4: L*2^16 - A*D.
    logic signed [TERM_W-1:0] term_next, term_reg;

    assign r1_off   = $signed({1'b0, rand_a, 1'b0}) - $signed(18'd65536);
    assign a32_next = $signed({1'b0, a_coeff}) * r1_off;
    assign p_next   = $signed({1'b0, rand_c}) * lead;

    assign diff = $signed({p_reg, 1'b0}) - $signed({{2{pos_s1_reg[31]}}, pos_s1_reg, 16'd0});
    assign dmag = diff[49] ? 50'(-diff) : 50'(diff);
    assign dsum = dmag + 50'd32768;
    assign d16_next = dsum[49:16];

    // Both roundings go to nearest with ties away from zero, on the magnitude.
    assign amag = a32_reg[36] ? 37'(-a32_reg) : 37'(a32_reg);
    assign asum = amag + 37'd32768;
    assign a16_next = a32_reg[36] ? -$signed({1'b0, asum[33:16]})
                                  :  $signed({1'b0, asum[33:16]});

    assign prod_next = a16_reg * $signed({1'b0, d16_reg});

    assign term_next = $signed({{6{lead_s3_reg[31]}}, lead_s3_reg, 16'd0}) - prod_reg;

    always_ff @(posedge clk)
    begin
        a32_reg     <= a32_next;
        p_reg       <= p_next;
        lead_s1_reg <= lead;
        pos_s1_reg  <= pos;
        a16_reg     <= a16_next;
        d16_reg     <= d16_next;
        lead_s2_reg <= lead_s1_reg;
        prod_reg    <= prod_next;
        lead_s3_reg <= lead_s2_reg;
        term_reg    <= term_next;
    end

    assign term = term_reg;

endmodule

FILE: hdl/wolf_pack_position_update.sv
// ----------------------------------------------------------------------------
// wolf_pack_position_update
// Grey wolf position update for one search variable: three leader terms,
// their rounded mean, saturation and clamping to the variable's limits.
// ----------------------------------------------------------------------------
//  Channel   Handshake          Payload
//  -------   ---------          -------
//  request   start / busy       leader values, position, limits, six randoms
//  result    done (1 cycle)     new_position
//  config    cfg_we             cfg_wdata (coefficient a, Q2.16)
//
//  A request is taken every cycle; busy is always low.
//  Results appear in request order.
//  The depth is set by the multiplier chain of the leader terms (four stages)
//  and the sum, rounded divide by three, saturation and clamp (five stages).
//  Reset clears the valid pipeline and sets the coefficient to 2.0.
//  The receiver cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
module wolf_pack_position_update
    import wpu_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    cfg_we,
    input  logic [COEF_W-1:0]       cfg_wdata,
    input  logic signed [VAL_W-1:0] alpha_value,
    input  logic signed [VAL_W-1:0] beta_value,
    input  logic signed [VAL_W-1:0] delta_value,
    input  logic signed [VAL_W-1:0] current_position,
    input  logic signed [VAL_W-1:0] lower_limit,
    input  logic signed [VAL_W-1:0] upper_limit,
    input  logic [RND_W-1:0]        rand_a_alpha,
    input  logic [RND_W-1:0]        rand_c_alpha,
    input  logic [RND_W-1:0]        rand_a_beta,
    input  logic [RND_W-1:0]        rand_c_beta,
    input  logic [RND_W-1:0]        rand_a_delta,
    input  logic [RND_W-1:0]        rand_c_delta,
    output logic                    done,
    output logic signed [VAL_W-1:0] new_position
);

    localparam int LATENCY = 9;
    localparam int LIM_DEPTH = LATENCY - 1;

    logic [COEF_W-1:0]        a_coeff_reg;
    logic [LATENCY-1:0]       vld_reg;
    logic                     accept;
    wpu_limits_t              lim_reg [LIM_DEPTH];

    logic signed [TERM_W-1:0] x_alpha, x_beta, x_delta;

    logic signed [SUM_W-1:0]  sum_next, sum_reg;
    logic [SUM_W-1:0]         msum;
    logic [MQ_W-1:0]          m_reg;
    logic                     neg_s6_reg, neg_s7_reg;

    logic                     sat_next, sat_reg;
    logic [16:0]              mh;
    logic [17:0]              qh_full;
    logic [15:0]              qh_reg;
    logic [16:0]              three_qh, rh_full;
    logic [1:0]               rh_reg;
    logic [15:0]              ml_reg;

    logic [17:0]              ql_full;
    logic [31:0]              q;
    logic [32:0]              negq;
    logic signed [VAL_W-1:0]  v_next, v_reg;
    logic signed [VAL_W-1:0]  clamp_next, pos_out_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_coeff_reg <= A_COEFF_RESET;
            vld_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                a_coeff_reg <= cfg_wdata;
            end
            vld_reg <= {vld_reg[LATENCY-2:0], accept};
        end
    end

    wpu_term u_term_alpha (
        .clk     (clk),
        .a_coeff (a_coeff_reg),
        .lead    (alpha_value),
        .pos     (current_position),
        .rand_a  (rand_a_alpha),
        .rand_c  (rand_c_alpha),
        .term    (x_alpha)
    );

    wpu_term u_term_beta (
        .clk     (clk),
        .a_coeff (a_coeff_reg),
        .lead    (beta_value),
        .pos     (current_position),
        .rand_a  (rand_a_beta),
        .rand_c  (rand_c_beta),
        .term    (x_beta)
    );

    wpu_term u_term_delta (
        .clk     (clk),
        .a_coeff (a_coeff_reg),
        .lead    (delta_value),
        .pos     (current_position),
        .rand_a  (rand_a_delta),
        .rand_c  (rand_c_delta),
        .term    (x_delta)
    );

    // Stage 5: exact sum of the three terms.
    assign sum_next = $signed({x_alpha[TERM_W-1], x_alpha})
                    + $signed({x_beta[TERM_W-1], x_beta})
                    + $signed({x_delta[TERM_W-1], x_delta});

    // Stage 6: |sum| plus half of 3*2^16, folded into one add, then the 2^16 shift.
    assign msum = (sum_reg[SUM_W-1] ? ~sum_reg : sum_reg)
                + (sum_reg[SUM_W-1] ? 55'd98305 : 55'd98304);

    // Stage 7: saturation check and the upper half of the divide by three.
    assign sat_next = neg_s6_reg ? (m_reg >= SAT_NEG_LIM) : (m_reg >= SAT_POS_LIM);
    assign mh       = m_reg[32:16];
    assign qh_full  = div3({2'b00, mh});
    assign three_qh = {qh_full[15:0], 1'b0} + {1'b0, qh_full[15:0]};
    assign rh_full  = mh - three_qh;

    // Stage 8: lower half of the divide, sign and saturation.
    assign ql_full = div3({1'b0, rh_reg, ml_reg});
    assign q       = {qh_reg, ql_full[15:0]};
    assign negq    = 33'd0 - {1'b0, q};

    always_comb
    begin
        if (sat_reg)
        begin
            v_next = neg_s7_reg ? VAL_MIN : VAL_MAX;
        end
        else if (neg_s7_reg)
        begin
            v_next = $signed(negq[31:0]);
        end
        else
        begin
            v_next = $signed(q);
        end
    end

    // Stage 9: clamp; with crossed limits the lower limit wins only for values below it.
    always_comb
    begin
        if (v_reg < lim_reg[LIM_DEPTH-1].lo)
        begin
            clamp_next = lim_reg[LIM_DEPTH-1].lo;
        end
        else if (v_reg > lim_reg[LIM_DEPTH-1].hi)
        begin
            clamp_next = lim_reg[LIM_DEPTH-1].hi;
        end
        else
        begin
            clamp_next = v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        lim_reg[0].lo <= lower_limit;
        lim_reg[0].hi <= upper_limit;
        for (int i = 1; i < LIM_DEPTH; i++)
        begin
            lim_reg[i] <= lim_reg[i-1];
        end
        sum_reg     <= sum_next;
        m_reg       <= msum[SUM_W-1:16];
        neg_s6_reg  <= sum_reg[SUM_W-1];
        neg_s7_reg  <= neg_s6_reg;
        sat_reg     <= sat_next;
        qh_reg      <= qh_full[15:0];
        rh_reg      <= rh_full[1:0];
        ml_reg      <= m_reg[15:0];
        v_reg       <= v_next;
        pos_out_reg <= clamp_next;
    end

    assign done         = vld_reg[LATENCY-1];
    assign new_position = pos_out_reg;

endmodule

FILE: hdl/wpu_checker.sv
// ----------------------------------------------------------------------------
// wpu_checker
// Port-level checks of the position update: fixed latency, clamping, never busy.
// ----------------------------------------------------------------------------
module wpu_checker
    import wpu_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    start,
    input logic                    busy,
    input logic                    done,
    input logic signed [VAL_W-1:0] lower_limit,
    input logic signed [VAL_W-1:0] upper_limit,
    input logic signed [VAL_W-1:0] new_position
);

    // Every accepted request gets its result.
    a_req_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##9 done)
        else $error("request did not produce a result after nine cycles");

    // No result without a matching earlier request.
    a_done_has_req: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 9))
        else $error("result without a matching request");

    // With ordered limits the result lies between them.
    a_in_limits: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (($past(lower_limit, 9) > $past(upper_limit, 9))
              || ((new_position >= $past(lower_limit, 9))
               && (new_position <= $past(upper_limit, 9)))))
        else $error("result outside the request's limits");

    // The pipeline takes a request in every cycle.
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy)
        else $error("request refused");

endmodule

bind wolf_pack_position_update wpu_checker u_wpu_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .lower_limit  (lower_limit),
    .upper_limit  (upper_limit),
    .new_position (new_position)
);

FILE: tb/wolf_pack_position_update_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wolf_pack_position_update_checker
// Watches the request, result and coefficient channels of the position update
// block. It keeps its own copy of the coefficient, predicts new_position for
// every accepted request and compares each result against the oldest pending
// prediction. It reports the mismatch count and the number of pending
// predictions to the testbench top.
// ----------------------------------------------------------------------------
module wolf_pack_position_update_checker
    import wpu_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic                    busy,
    input  logic                    cfg_we,
    input  logic [COEF_W-1:0]       cfg_wdata,
    input  logic signed [VAL_W-1:0] alpha_value,
    input  logic signed [VAL_W-1:0] beta_value,
    input  logic signed [VAL_W-1:0] delta_value,
    input  logic signed [VAL_W-1:0] current_position,
    input  logic signed [VAL_W-1:0] lower_limit,
    input  logic signed [VAL_W-1:0] upper_limit,
    input  logic [RND_W-1:0]        rand_a_alpha,
    input  logic [RND_W-1:0]        rand_c_alpha,
    input  logic [RND_W-1:0]        rand_a_beta,
    input  logic [RND_W-1:0]        rand_c_beta,
    input  logic [RND_W-1:0]        rand_a_delta,
    input  logic [RND_W-1:0]        rand_c_delta,
    input  logic                    done,
    input  logic signed [VAL_W-1:0] new_position,
    output int                      mismatch_count,
    output int                      pending_count
);

    localparam longint Q16_ONE = 65536;

    logic [COEF_W-1:0]       coeff_a;
    logic signed [VAL_W-1:0] expected_positions[$];

    // Division rounded to nearest with ties away from zero; den is positive.
    function automatic longint round_nearest(input longint num, input longint den);
        longint mag;
        longint quot;
        mag  = (num < 0) ? -num : num;
        quot = (mag + den / 2) / den;
        return (num < 0) ? -quot : quot;
    endfunction

    // One leader term L - A*D, kept in Q.32.
    function automatic longint leader_term(input longint leader, input longint frac_a,
                                           input longint frac_c);
        longint step_q16;
        longint gap;
        longint dist_q16;
        step_q16 = round_nearest(longint'(coeff_a) * (2 * frac_a - Q16_ONE), Q16_ONE);
        gap      = 2 * frac_c * leader - longint'(current_position) * Q16_ONE;
        if (gap < 0)
        begin
            gap = -gap;
        end
        dist_q16 = round_nearest(gap, Q16_ONE);
        return leader * Q16_ONE - step_q16 * dist_q16;
    endfunction

    function automatic logic signed [VAL_W-1:0] predict_position();
        longint total;
        longint mean;
        total = leader_term(alpha_value, rand_a_alpha, rand_c_alpha)
              + leader_term(beta_value, rand_a_beta, rand_c_beta)
              + leader_term(delta_value, rand_a_delta, rand_c_delta);
        mean = round_nearest(total, 3 * Q16_ONE);
        if (mean > longint'(VAL_MAX))
        begin
            mean = VAL_MAX;
        end
        if (mean < longint'(VAL_MIN))
        begin
            mean = VAL_MIN;
        end
        // With crossed limits the lower limit wins only for values below it.
        if (mean < longint'(lower_limit))
        begin
            mean = lower_limit;
        end
        else if (mean > longint'(upper_limit))
        begin
            mean = upper_limit;
        end
        return mean[VAL_W-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coeff_a = A_COEFF_RESET;
            expected_positions.delete();
            mismatch_count = 0;
            pending_count  = 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_positions.size() == 0)
                begin
                    $error("new_position: expected none, actual %0d", new_position);
                    mismatch_count++;
                end
                else if (new_position !== expected_positions[0])
                begin
                    $error("new_position: expected %0d, actual %0d",
                           expected_positions[0], new_position);
                    mismatch_count++;
                    void'(expected_positions.pop_front());
                end
                else
                begin
                    void'(expected_positions.pop_front());
                end
            end
            // A request sees the coefficient as it stood before this edge.
            if (start && !busy)
            begin
                expected_positions.push_back(predict_position());
            end
            if (cfg_we)
            begin
                coeff_a = cfg_wdata;
            end
            pending_count = expected_positions.size();
        end
    end

endmodule

FILE: tb/wolf_pack_position_update_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wolf_pack_position_update_test
// Drives the position update block with a directed set of corner requests and
// then several phases of random requests, each under its own coefficient a.
// A checker beside the block predicts and compares every result; this top
// only makes stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module wolf_pack_position_update_test;
    import wpu_pkg::*;

    localparam int CYCLE_LIMIT    = 100000;
    localparam int PHASE_REQUESTS = 55;
    localparam int DRAIN_CYCLES   = 20;

    typedef struct {
        logic signed [VAL_W-1:0] alpha;
        logic signed [VAL_W-1:0] beta;
        logic signed [VAL_W-1:0] delta;
        logic signed [VAL_W-1:0] pos;
        logic signed [VAL_W-1:0] lo;
        logic signed [VAL_W-1:0] hi;
        logic [RND_W-1:0]        ra_alpha;
        logic [RND_W-1:0]        rc_alpha;
        logic [RND_W-1:0]        ra_beta;
        logic [RND_W-1:0]        rc_beta;
        logic [RND_W-1:0]        ra_delta;
        logic [RND_W-1:0]        rc_delta;
    } move_request_t;

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    logic                    cfg_we;
    logic [COEF_W-1:0]       cfg_wdata;
    logic signed [VAL_W-1:0] alpha_value;
    logic signed [VAL_W-1:0] beta_value;
    logic signed [VAL_W-1:0] delta_value;
    logic signed [VAL_W-1:0] current_position;
    logic signed [VAL_W-1:0] lower_limit;
    logic signed [VAL_W-1:0] upper_limit;
    logic [RND_W-1:0]        rand_a_alpha;
    logic [RND_W-1:0]        rand_c_alpha;
    logic [RND_W-1:0]        rand_a_beta;
    logic [RND_W-1:0]        rand_c_beta;
    logic [RND_W-1:0]        rand_a_delta;
    logic [RND_W-1:0]        rand_c_delta;
    logic                    done;
    logic signed [VAL_W-1:0] new_position;
    int                      mismatch_count;
    int                      pending_count;
    int unsigned             cycle_count;

    wolf_pack_position_update dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .alpha_value      (alpha_value),
        .beta_value       (beta_value),
        .delta_value      (delta_value),
        .current_position (current_position),
        .lower_limit      (lower_limit),
        .upper_limit      (upper_limit),
        .rand_a_alpha     (rand_a_alpha),
        .rand_c_alpha     (rand_c_alpha),
        .rand_a_beta      (rand_a_beta),
        .rand_c_beta      (rand_c_beta),
        .rand_a_delta     (rand_a_delta),
        .rand_c_delta     (rand_c_delta),
        .done             (done),
        .new_position     (new_position)
    );

    wolf_pack_position_update_checker checker_i (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .alpha_value      (alpha_value),
        .beta_value       (beta_value),
        .delta_value      (delta_value),
        .current_position (current_position),
        .lower_limit      (lower_limit),
        .upper_limit      (upper_limit),
        .rand_a_alpha     (rand_a_alpha),
        .rand_c_alpha     (rand_c_alpha),
        .rand_a_beta      (rand_a_beta),
        .rand_c_beta      (rand_c_beta),
        .rand_a_delta     (rand_a_delta),
        .rand_c_delta     (rand_c_delta),
        .done             (done),
        .new_position     (new_position),
        .mismatch_count   (mismatch_count),
        .pending_count    (pending_count)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("** wolf_pack_position_update: FAILED **");
            $finish;
        end
    end

    function automatic move_request_t quiet_request();
        move_request_t req;
        req.alpha    = '0;
        req.beta     = '0;
        req.delta    = '0;
        req.pos      = '0;
        req.lo       = VAL_MIN;
        req.hi       = VAL_MAX;
        req.ra_alpha = '0;
        req.rc_alpha = '0;
        req.ra_beta  = '0;
        req.rc_beta  = '0;
        req.ra_delta = '0;
        req.rc_delta = '0;
        return req;
    endfunction

    function automatic logic signed [VAL_W-1:0] random_value();
        logic signed [VAL_W-1:0] v;
        case ($urandom_range(0, 5))
            0: v = $urandom;
            1:
            begin
                case ($urandom_range(0, 3))
                    0: v = VAL_MAX;
                    1: v = VAL_MIN;
                    2: v = '0;
                    default: v = '1;
                endcase
            end
            2:
            begin
                v = $urandom_range(0, 32'h3_FFFF);
                v = v - 32'sh2_0000;
            end
            default:
            begin
                v = $urandom_range(0, 32'h1FF_FFFF);
                v = v - 32'sh100_0000;
            end
        endcase
        return v;
    endfunction

    function automatic logic [RND_W-1:0] random_fraction();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return RND_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // Leaders mostly cluster around one point near the agent, as they do late
    // in a search; the rest are drawn independently across the whole range.
    function automatic move_request_t random_request();
        move_request_t           req;
        logic signed [VAL_W-1:0] center;
        logic signed [VAL_W-1:0] swap;
        logic signed [VAL_W-1:0] spread;
        req = quiet_request();
        if ($urandom_range(0, 3) != 0)
        begin
            center    = random_value();
            spread    = $urandom_range(0, 32'h7_FFFF);
            req.alpha = center + $signed($urandom_range(0, 32'hF_FFFF)) - spread;
            req.beta  = center + $signed($urandom_range(0, 32'hF_FFFF)) - spread;
            req.delta = center + $signed($urandom_range(0, 32'hF_FFFF)) - spread;
            req.pos   = center + $signed($urandom_range(0, 32'h3F_FFFF)) - 32'sh20_0000;
        end
        else
        begin
            req.alpha = random_value();
            req.beta  = random_value();
            req.delta = random_value();
            req.pos   = random_value();
        end
        req.ra_alpha = random_fraction();
        req.rc_alpha = random_fraction();
        req.ra_beta  = random_fraction();
        req.rc_beta  = random_fraction();
        req.ra_delta = random_fraction();
        req.rc_delta = random_fraction();
        req.lo = random_value();
        req.hi = random_value();
        case ($urandom_range(0, 5))
            0:
            begin
                req.lo = VAL_MIN;
                req.hi = VAL_MAX;
            end
            1, 2:
            begin
                if (req.lo > req.hi)
                begin
                    swap   = req.lo;
                    req.lo = req.hi;
                    req.hi = swap;
                end
            end
            3:
            begin
                if (req.lo < req.hi)
                begin
                    swap   = req.lo;
                    req.lo = req.hi;
                    req.hi = swap;
                end
            end
            4:
            begin
                req.lo = req.alpha - $signed($urandom_range(0, 32'h3_FFFF));
                req.hi = req.alpha + $signed($urandom_range(0, 32'h3_FFFF));
            end
            default: req.hi = req.lo;
        endcase
        return req;
    endfunction

    // Holds the request until it is taken, then idles for gap cycles.
    task automatic issue_request(input move_request_t req, input int gap);
        start            <= 1'b1;
        alpha_value      <= req.alpha;
        beta_value       <= req.beta;
        delta_value      <= req.delta;
        current_position <= req.pos;
        lower_limit      <= req.lo;
        upper_limit      <= req.hi;
        rand_a_alpha     <= req.ra_alpha;
        rand_c_alpha     <= req.rc_alpha;
        rand_a_beta      <= req.ra_beta;
        rand_c_beta      <= req.rc_beta;
        rand_a_delta     <= req.ra_delta;
        rand_c_delta     <= req.rc_delta;
        do
            @(posedge clk);
        while (busy);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_coeff(input logic [COEF_W-1:0] value);
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin
        move_request_t     req;
        logic [COEF_W-1:0] coeff_plan[7];
        bit                burst;

        cycle_count      = 0;
        rst_n            <= 1'b0;
        start            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_wdata        <= '0;
        alpha_value      <= '0;
        beta_value       <= '0;
        delta_value      <= '0;
        current_position <= '0;
        lower_limit      <= '0;
        upper_limit      <= '0;
        rand_a_alpha     <= '0;
        rand_c_alpha     <= '0;
        rand_a_beta      <= '0;
        rand_c_beta      <= '0;
        rand_a_delta     <= '0;
        rand_c_delta     <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests under the reset coefficient of 2.0.
        req = quiet_request();
        issue_request(req, 0);

        // Leaders at the top, agent at the bottom: A near +2 drives the mean
        // below -2^31 and it saturates; with r1 at zero it saturates high.
        req.alpha = VAL_MAX;
        req.beta  = VAL_MAX;
        req.delta = VAL_MAX;
        req.pos   = VAL_MIN;
        req.ra_alpha = '1;
        req.ra_beta  = '1;
        req.ra_delta = '1;
        req.rc_alpha = '1;
        req.rc_beta  = '1;
        req.rc_delta = '1;
        issue_request(req, 1);
        req.ra_alpha = '0;
        req.ra_beta  = '0;
        req.ra_delta = '0;
        issue_request(req, 0);
        req.alpha = VAL_MIN;
        req.beta  = VAL_MIN;
        req.delta = VAL_MIN;
        req.pos   = VAL_MAX;
        issue_request(req, 2);

        // r1 at one half makes A zero, so the mean is the leaders' mean (10.0).
        req = quiet_request();
        req.alpha = 32'sd655360;
        req.beta  = 32'sd655360;
        req.delta = 32'sd655360;
        req.pos   = 32'sd655360;
        req.ra_alpha = 16'd32768;
        req.ra_beta  = 16'd32768;
        req.ra_delta = 16'd32768;
        req.rc_alpha = 16'd32768;
        req.rc_beta  = 16'd32768;
        req.rc_delta = 16'd32768;
        req.lo = 32'sd1310720;
        req.hi = 32'sd1966080;
        issue_request(req, 0);
        req.lo = 32'sd0;
        req.hi = 32'sd327680;
        issue_request(req, 0);
        // Crossed limits: below the lower limit, then above both.
        req.lo = 32'sd1310720;
        req.hi = 32'sd327680;
        issue_request(req, 3);
        req.lo = 32'sd327680;
        req.hi = 32'sd131072;
        issue_request(req, 0);
        req.lo = 32'sd655360;
        req.hi = 32'sd655360;
        issue_request(req, 0);
        req.lo = VAL_MAX;
        req.hi = VAL_MIN;
        issue_request(req, 1);

        // Half-step distances exercise rounding ties of either sign.
        req = quiet_request();
        req.alpha = 32'sd1;
        req.beta  = 32'sd1;
        req.delta = 32'sd1;
        req.rc_alpha = 16'd16384;
        req.rc_beta  = 16'd16384;
        req.rc_delta = 16'd16384;
        req.ra_alpha = '1;
        req.ra_beta  = '1;
        req.ra_delta = '1;
        issue_request(req, 0);
        req.alpha = -32'sd1;
        req.beta  = -32'sd1;
        req.delta = -32'sd1;
        issue_request(req, 0);

        req = quiet_request();
        req.alpha = 32'sd123456789;
        req.beta  = -32'sd987654321;
        req.delta = 32'sd55555;
        req.pos   = -32'sd424242;
        req.ra_alpha = '0;
        req.rc_alpha = '1;
        req.ra_beta  = '1;
        req.rc_beta  = '0;
        req.ra_delta = 16'h5555;
        req.rc_delta = 16'hAAAA;
        issue_request(req, 0);
        req = quiet_request();
        req.pos = VAL_MAX;
        req.ra_alpha = '1;
        issue_request(req, 4);
        req = quiet_request();
        req.alpha = '1;
        req.beta  = '1;
        req.delta = '1;
        req.pos   = '1;
        req.lo    = '1;
        req.hi    = '1;
        req.ra_alpha = '1;
        req.rc_alpha = '1;
        req.ra_beta  = '1;
        req.rc_beta  = '1;
        req.ra_delta = '1;
        req.rc_delta = '1;
        issue_request(req, 0);
        wait_drained();

        // Random phases, each under its own coefficient.
        coeff_plan[0] = '0;
        coeff_plan[1] = '1;
        coeff_plan[2] = 18'd65536;
        coeff_plan[3] = 18'd1;
        coeff_plan[4] = COEF_W'($urandom_range(0, 131072));
        coeff_plan[5] = COEF_W'($urandom_range(131073, 262143));
        coeff_plan[6] = A_COEFF_RESET;
        foreach (coeff_plan[p])
        begin
            write_coeff(coeff_plan[p]);
            burst = 1'b0;
            for (int n = 0; n < PHASE_REQUESTS; n++)
            begin
                if ($urandom_range(0, 15) == 0)
                begin
                    burst = !burst;
                end
                issue_request(random_request(), burst ? 0 : $urandom_range(0, 5));
                if ($urandom_range(0, 49) == 0)
                begin
                    wait_drained();
                end
            end
            wait_drained();
        end

        // Any stray result would show up in this window.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("** wolf_pack_position_update: PASSED **");
        end
        else
        begin
            $display("** wolf_pack_position_update: FAILED **");
        end
        $finish;
    end

endmodule
